[sv/hsl2rgb_pkg.sv]
`default_nettype none

package hsl2rgb_pkg;

    // payload widths of the two channels
    localparam int unsigned IN_W  = 16;
    localparam int unsigned OUT_W = 8;

    // color channels, in output order
    localparam int unsigned NUM_CH = 3;
    localparam int unsigned CH_RED   = 0;
    localparam int unsigned CH_GREEN = 1;
    localparam int unsigned CH_BLUE  = 2;

    // register stages from input to output
    localparam int unsigned STAGES = 6;

    // largest channel value
    localparam logic [OUT_W-1:0] OUT_MAX = 8'hFF;

    // piece of the hue curve a channel falls on
    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_HIGH,
        SEG_FALL,
        SEG_LOW
    } t_seg;

endpackage

`default_nettype wire

[sv/hsl2rgb_hsl_if.sv]
`default_nettype none

interface hsl2rgb_hsl_if;

    logic                         valid;
    logic                         ready;
    logic [hsl2rgb_pkg::IN_W-1:0] hue;
    logic [hsl2rgb_pkg::IN_W-1:0] saturation;
    logic [hsl2rgb_pkg::IN_W-1:0] lightness;

    modport source (
        output valid,
        output hue,
        output saturation,
        output lightness,
        input  ready
    );

    modport sink (
        input  valid,
        input  hue,
        input  saturation,
        input  lightness,
        output ready
    );

endinterface

`default_nettype wire

[sv/hsl2rgb_rgb_if.sv]
`default_nettype none

interface hsl2rgb_rgb_if;

    logic                          valid;
    logic                          ready;
    logic [hsl2rgb_pkg::OUT_W-1:0] red;
    logic [hsl2rgb_pkg::OUT_W-1:0] green;
    logic [hsl2rgb_pkg::OUT_W-1:0] blue;

    modport source (
        output valid,
        output red,
        output green,
        output blue,
        input  ready
    );

    modport sink (
        input  valid,
        input  red,
        input  green,
        input  blue,
        output ready
    );

endinterface

`default_nettype wire

[sv/hsl_to_rgb_converter.sv]
`default_nettype none

// HSL to RGB color converter. Hue, saturation and lightness come in as unsigned
// fractions with FRAC_BITS fraction bits (values above 1.0 are clamped to 1.0); red,
// green and blue go out as floor(255 * channel), saturated at 255. The block is a
// six-stage pipeline that takes one beat in every clock cycle while the output is
// not stalled; each beat passes the clamp, product, p/q, ramp, sum and scale stages
// in order. Among them are two multiplier stages (lightness times saturation, then
// the ramp slope times the hue offset for each of the three channels) and the wide
// multiply-by-255 stage. Each stage holds its beat while the next one is full, so a
// stall on the output only backs up as far as needed and no beat is lost or
// repeated. The block keeps no state between beats.
module hsl_to_rgb_converter #(
    parameter int unsigned FRAC_BITS = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    hsl2rgb_hsl_if.sink           i_hsl,
    hsl2rgb_rgb_if.source         o_rgb
);

    // value, hue and product widths
    localparam int unsigned VW = FRAC_BITS + 1;
    localparam int unsigned XW = (VW > hsl2rgb_pkg::IN_W) ? VW : hsl2rgb_pkg::IN_W;
    localparam int unsigned HW = FRAC_BITS + 4;
    localparam int unsigned PW = 2 * VW;
    localparam int unsigned MW = PW + 8;
    localparam int unsigned CW = MW - 2 * FRAC_BITS;
    localparam int unsigned NS = hsl2rgb_pkg::STAGES;
    localparam int unsigned NC = hsl2rgb_pkg::NUM_CH;

    localparam logic [XW-1:0] X_ONE   = XW'(1) << FRAC_BITS;
    localparam logic [VW-1:0] V_ONE   = VW'(1) << FRAC_BITS;
    localparam logic [VW:0]   L_ONE   = (VW + 1)'(1) << FRAC_BITS;
    localparam logic [HW-1:0] H_ONE   = HW'(1) << FRAC_BITS;
    localparam logic [HW-1:0] H_TWO   = HW'(2) << FRAC_BITS;
    localparam logic [HW-1:0] H_THREE = HW'(3) << FRAC_BITS;
    localparam logic [HW-1:0] H_FOUR  = HW'(4) << FRAC_BITS;
    localparam logic [HW-1:0] H_SIX   = HW'(6) << FRAC_BITS;
    localparam logic [PW-1:0] P_RND   = (PW'(1) << FRAC_BITS) - PW'(1);
    localparam logic [CW-1:0] C_MAX   = CW'(hsl2rgb_pkg::OUT_MAX);

    // clamp an input fraction to one
    function automatic logic [VW-1:0] clamp_in(input logic [hsl2rgb_pkg::IN_W-1:0] v);
        logic [XW-1:0] w;
        w = XW'(v);
        if (w > X_ONE) begin
            w = X_ONE;
        end
        return w[VW-1:0];
    endfunction

    // pipeline flow control
    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] stage_en;

    // stage 1: clamped inputs
    logic [VW-1:0] r_s1_h, r_s1_s, r_s1_l;
    logic [VW-1:0] n_s1_h, n_s1_s, n_s1_l;

    // stage 2: lightness times saturation, channel hues
    logic [PW-1:0] r_s2_ls, n_s2_ls;
    logic [VW-1:0] r_s2_l, r_s2_s;
    logic          r_s2_lo, n_s2_lo;
    logic [HW-1:0] r_s2_h6 [NC];
    logic [HW-1:0] n_s2_h6 [NC];
    logic [HW-1:0] h6_base;
    logic [HW-1:0] h6_red;

    // stage 3: p, q and slope, segment and hue offset per channel
    logic [VW-1:0] r_s3_p, r_s3_q, r_s3_d;
    logic [VW-1:0] n_s3_p, n_s3_q, n_s3_d;
    hsl2rgb_pkg::t_seg r_s3_seg [NC];
    hsl2rgb_pkg::t_seg n_s3_seg [NC];
    logic [VW-1:0] r_s3_t [NC];
    logic [VW-1:0] n_s3_t [NC];
    logic [PW-1:0] ls_ceil;
    logic [VW:0]   q_wide;
    logic [VW:0]   p_wide;
    logic [HW-1:0] t_fall [NC];

    // stage 4: base level and ramp product per channel
    logic [VW-1:0] r_s4_base [NC];
    logic [VW-1:0] n_s4_base [NC];
    logic [PW-1:0] r_s4_prod [NC];
    logic [PW-1:0] n_s4_prod [NC];

    // stage 5: channel accumulator
    logic [PW-1:0] r_s5_acc [NC];
    logic [PW-1:0] n_s5_acc [NC];

    // stage 6: scaled 8-bit channels
    logic [hsl2rgb_pkg::OUT_W-1:0] r_s6_c [NC];
    logic [hsl2rgb_pkg::OUT_W-1:0] n_s6_c [NC];
    logic [MW-1:0] scaled [NC];
    logic [CW-1:0] chan   [NC];

    // a stage takes a beat when it is empty or its beat moves on
    always_comb begin
        stage_en[NS-1] = !r_vld[NS-1] || o_rgb.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
        n_vld[0] = i_hsl.valid;
        for (int k = 1; k < NS; k++) begin
            n_vld[k] = r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign i_hsl.ready = stage_en[0];

    // stage 1: clamp
    always_comb begin
        n_s1_h = clamp_in(i_hsl.hue);
        n_s1_s = clamp_in(i_hsl.saturation);
        n_s1_l = clamp_in(i_hsl.lightness);
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_s1_h <= n_s1_h;
            r_s1_s <= n_s1_s;
            r_s1_l <= n_s1_l;
        end
    end

    // stage 2: product l*s, six times hue with per-channel offset and wrap
    always_comb begin
        n_s2_ls = PW'(r_s1_l) * PW'(r_s1_s);
        n_s2_lo = ({1'b0, r_s1_l} << 1) < L_ONE;
        h6_base = (HW'(r_s1_h) << 2) + (HW'(r_s1_h) << 1);
        h6_red  = h6_base + H_TWO;
        n_s2_h6[hsl2rgb_pkg::CH_RED]   = (h6_red > H_SIX) ? (h6_red - H_SIX) : h6_red;
        n_s2_h6[hsl2rgb_pkg::CH_GREEN] = h6_base;
        n_s2_h6[hsl2rgb_pkg::CH_BLUE]  = (h6_base < H_TWO) ? (h6_base + H_FOUR)
                                                            : (h6_base - H_TWO);
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r_s2_ls <= n_s2_ls;
            r_s2_l  <= r_s1_l;
            r_s2_s  <= r_s1_s;
            r_s2_lo <= n_s2_lo;
            r_s2_h6 <= n_s2_h6;
        end
    end

    // stage 3: q = l + floor(ls) below half, l + s - ceil(ls) otherwise; p = 2l - q
    always_comb begin
        ls_ceil = (r_s2_ls + P_RND) >> FRAC_BITS;
        if (r_s2_lo) begin
            q_wide = (VW + 1)'(r_s2_l) + (VW + 1)'(r_s2_ls >> FRAC_BITS);
        end else begin
            q_wide = (VW + 1)'(r_s2_l) + (VW + 1)'(r_s2_s) - (VW + 1)'(ls_ceil);
        end
        n_s3_q = q_wide[VW-1:0];
        p_wide = ((VW + 1)'(r_s2_l) << 1) - (VW + 1)'(n_s3_q);
        n_s3_p = p_wide[VW-1:0];
        n_s3_d = n_s3_q - n_s3_p;
        for (int c = 0; c < NC; c++) begin
            t_fall[c] = H_FOUR - r_s2_h6[c];
            if (r_s2_h6[c] < H_ONE) begin
                n_s3_seg[c] = hsl2rgb_pkg::SEG_RISE;
                n_s3_t[c]   = r_s2_h6[c][VW-1:0];
            end else if (r_s2_h6[c] < H_THREE) begin
                n_s3_seg[c] = hsl2rgb_pkg::SEG_HIGH;
                n_s3_t[c]   = '0;
            end else if (r_s2_h6[c] < H_FOUR) begin
                n_s3_seg[c] = hsl2rgb_pkg::SEG_FALL;
                n_s3_t[c]   = t_fall[c][VW-1:0];
            end else begin
                n_s3_seg[c] = hsl2rgb_pkg::SEG_LOW;
                n_s3_t[c]   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[2]) begin
            r_s3_p   <= n_s3_p;
            r_s3_q   <= n_s3_q;
            r_s3_d   <= n_s3_d;
            r_s3_seg <= n_s3_seg;
            r_s3_t   <= n_s3_t;
        end
    end

    // stage 4: base level and slope times hue offset
    always_comb begin
        for (int c = 0; c < NC; c++) begin
            unique case (r_s3_seg[c])
                hsl2rgb_pkg::SEG_HIGH: n_s4_base[c] = r_s3_q;
                hsl2rgb_pkg::SEG_RISE,
                hsl2rgb_pkg::SEG_FALL,
                hsl2rgb_pkg::SEG_LOW:  n_s4_base[c] = r_s3_p;
                default:               n_s4_base[c] = r_s3_p;
            endcase
            n_s4_prod[c] = PW'(r_s3_d) * PW'(r_s3_t[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[3]) begin
            r_s4_base <= n_s4_base;
            r_s4_prod <= n_s4_prod;
        end
    end

    // stage 5: channel fraction at double precision
    always_comb begin
        for (int c = 0; c < NC; c++) begin
            n_s5_acc[c] = (PW'(r_s4_base[c]) << FRAC_BITS) + r_s4_prod[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[4]) begin
            r_s5_acc <= n_s5_acc;
        end
    end

    // stage 6: times 255, truncate, saturate
    always_comb begin
        for (int c = 0; c < NC; c++) begin
            scaled[c] = (MW'(r_s5_acc[c]) << 8) - MW'(r_s5_acc[c]);
            chan[c]   = scaled[c][2*FRAC_BITS +: CW];
            n_s6_c[c] = (chan[c] > C_MAX) ? hsl2rgb_pkg::OUT_MAX
                                          : chan[c][hsl2rgb_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[5]) begin
            r_s6_c <= n_s6_c;
        end
    end

    // output beat
    assign o_rgb.valid = r_vld[NS-1];
    assign o_rgb.red   = r_s6_c[hsl2rgb_pkg::CH_RED];
    assign o_rgb.green = r_s6_c[hsl2rgb_pkg::CH_GREEN];
    assign o_rgb.blue  = r_s6_c[hsl2rgb_pkg::CH_BLUE];

`ifndef ASSERT_OFF
    // reset empties every stage
    a_flush: assert property (@(posedge i_clk) !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");

    // wrapped channel hues stay within one turn
    a_hue_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r_s2_h6[0] <= H_SIX) && (r_s2_h6[1] <= H_SIX)
                     && (r_s2_h6[2] <= H_SIX))
        else $error("channel hue out of range");

    // q never exceeds one
    a_q_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_s3_q <= V_ONE))
        else $error("q above one");

    // p never exceeds q, so the slope is non-negative
    a_pq_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_s3_p <= r_s3_q))
        else $error("p above q");
`endif

endmodule

`default_nettype wire
